@@ rtl/vwalu_pkg.sv @@
// Shared constants, function codes and width-wrap helper for the wrapping ALU.
package vwalu_pkg;

    localparam int DATA_W  = 16;
    localparam int WIDTH_W = 5;
    localparam int FUNC_W  = 2;

    localparam logic [WIDTH_W-1:0] MAX_WIDTH = 5'd16;

    localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUB  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUL  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FACT = 2'd3;

    typedef logic [DATA_W-1:0] t_word;

    // Keep the low w bits of x and copy bit w-1 into all bits above; w is 1..16.
    function automatic t_word wrap_word(input t_word x, input logic [WIDTH_W-1:0] w);
        t_word      v;
        logic [3:0] sidx;
        logic       sbit;
        sidx = 4'(w - 5'd1);
        sbit = x[sidx];
        for (int k = 0; k < DATA_W; k++) begin
            v[k] = (5'(k) < w) ? x[k] : sbit;
        end
        return v;
    endfunction

endpackage

@@ rtl/variable_width_wrapping_alu.sv @@
// Top level: configurable-width wrapping ALU with one shared adder and multiplier.
// Add, subtract, multiply and a negative factorial are registered through the execute and
// done states and show on m_axis once the output slot is free. Factorial of n >= 0 runs one
// multiply per cycle through the shared 16x16 multiplier until the counter passes n or the
// product is zero; at 16 bits the product wraps to zero after the multiply by 18. Throughput:
// one item at a time; s_axis_tready is high only while the sequencer is idle. Reset
// (i_rst_n low at a clock edge): sequencer idles, output drops valid, width goes to 16.
module variable_width_wrapping_alu (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vwalu_pkg::WIDTH_W-1:0]  i_cfg_wdata,    // width_bits
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [2*vwalu_pkg::DATA_W-1:0] s_axis_tdata,   // operand_a, operand_b
    input  logic [vwalu_pkg::FUNC_W-1:0]   s_axis_tuser,   // func
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [vwalu_pkg::DATA_W-1:0]   m_axis_tdata    // result
);
    import vwalu_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_FACT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [WIDTH_W-1:0]  r_width;
    logic [FUNC_W-1:0]   r_func;
    t_word               r_a, n_a;
    t_word               r_b, n_b;
    t_word               r_acc, n_acc;
    logic                r_out_valid, n_out_valid;
    t_word               r_out, n_out;

    logic [WIDTH_W-1:0]  w_act;
    logic                in_fire;
    logic                is_sub;
    t_word               addend;
    t_word               sum;
    t_word               mul_x;
    logic [2*DATA_W-1:0] prod;
    logic                out_free;

    always_comb begin
        if (r_width == '0) begin
            w_act = 5'd1;
        end else if (r_width > MAX_WIDTH) begin
            w_act = MAX_WIDTH;
        end else begin
            w_act = r_width;
        end
    end

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // Shared arithmetic: one adder and one 16x16 multiplier.
    assign is_sub = (r_func == FUNC_SUB);
    assign addend = is_sub ? ~r_b : r_b;
    assign sum    = DATA_W'(r_a + addend + t_word'(is_sub));
    assign mul_x  = (r_state == ST_FACT) ? r_acc : r_a;
    assign prod   = mul_x * r_b;

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_a     = s_axis_tdata[DATA_W-1:0];
                    n_b     = s_axis_tdata[2*DATA_W-1:DATA_W];
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_DONE;
                case (r_func)
                    FUNC_ADD, FUNC_SUB: n_acc = wrap_word(sum, w_act);
                    FUNC_MUL:           n_acc = wrap_word(prod[DATA_W-1:0], w_act);
                    FUNC_FACT: begin
                        if (r_a[DATA_W-1]) begin
                            n_acc = '0;
                        end else begin
                            // Start the running product at 1 and the step counter at 2.
                            n_acc   = wrap_word(t_word'(1), w_act);
                            n_b     = t_word'(2);
                            n_state = ST_FACT;
                        end
                    end
                    default: n_acc = '0;
                endcase
            end
            ST_FACT: begin
                // Stop once the counter passes n or the product has wrapped to zero.
                if (r_acc == '0 || r_b > r_a) begin
                    n_state = ST_DONE;
                end else begin
                    n_acc = wrap_word(prod[DATA_W-1:0], w_act);
                    n_b   = DATA_W'(r_b + t_word'(1));
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_acc;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_width     <= MAX_WIDTH;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_out <= n_out;
        if (in_fire) begin
            r_func <= s_axis_tuser;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

@@ rtl/vwalu_checker.sv @@
// Port-level checker for the wrapping ALU and its bind to the top level.
module vwalu_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [vwalu_pkg::DATA_W-1:0]   m_axis_tdata
);
    import vwalu_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // Count items taken but not yet delivered.
    always_comb begin
        n_cnt = r_cnt;
        if (in_fire && !out_fire) begin
            n_cnt = 2'(r_cnt + 2'd1);
        end else if (out_fire && !in_fire) begin
            n_cnt = 2'(r_cnt - 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input ready right after an item was taken");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_cnt != 2'd0)
        else $error("result shown with no item outstanding");

    a_ready_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_cnt == 2'd0 || r_cnt == 2'd1)
        else $error("ready while more than one item outstanding");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind variable_width_wrapping_alu vwalu_checker u_vwalu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
